// ----- src/gdm_pkg.sv -----
package gdm_pkg;

	// exponent width; the infinity codes follow from it
	localparam int EXP_W = 32;

	localparam logic signed [EXP_W-1:0] POS_INF = {1'b0, {(EXP_W-1){1'b1}}};
	localparam logic signed [EXP_W-1:0] NEG_INF = {1'b1, {(EXP_W-2){1'b0}}, 1'b1};
	localparam logic signed [EXP_W-1:0] MIN_CODE = {1'b1, {(EXP_W-1){1'b0}}};
	localparam logic signed [EXP_W-1:0] FIN_MAX = {1'b0, {(EXP_W-2){1'b1}}, 1'b0};
	localparam logic signed [EXP_W-1:0] FIN_MIN = {1'b1, {(EXP_W-3){1'b0}}, 2'b10};

	typedef enum logic [2:0] {
		CMD_PROD     = 3'd0,
		CMD_RES      = 3'd1,
		CMD_DRES     = 3'd2,
		CMD_HPROD    = 3'd3,
		CMD_HRES     = 3'd4,
		CMD_HDRES    = 3'd5
	} cmd_t;

	// one exponent together with its clamp flag
	typedef struct packed {
		logic signed [EXP_W-1:0] val;
		logic                    sat;
	} exp_t;

	// one result beat
	typedef struct packed {
		logic signed [EXP_W-1:0] gamma;
		logic signed [EXP_W-1:0] delta;
		logic                    undefined;
		logic                    saturated;
	} res_t;

endpackage

// ----- src/gdm_alu.sv -----
module gdm_alu (
	input  logic [2:0]                       command,
	input  logic signed [gdm_pkg::EXP_W-1:0] a_gamma,
	input  logic signed [gdm_pkg::EXP_W-1:0] a_delta,
	input  logic signed [gdm_pkg::EXP_W-1:0] b_gamma,
	input  logic signed [gdm_pkg::EXP_W-1:0] b_delta,
	output gdm_pkg::res_t                    res
);

	// bare sign bit reads as -inf
	function automatic logic signed [gdm_pkg::EXP_W-1:0] norm(
		input logic signed [gdm_pkg::EXP_W-1:0] v
	);
		return (v == gdm_pkg::MIN_CODE) ? gdm_pkg::NEG_INF : v;
	endfunction

	// a + b or a - b with one guard bit, clamped to the finite range
	function automatic gdm_pkg::exp_t sat_op(
		input logic signed [gdm_pkg::EXP_W-1:0] a,
		input logic signed [gdm_pkg::EXP_W-1:0] b,
		input logic                             sub
	);
		logic signed [gdm_pkg::EXP_W:0] ax;
		logic signed [gdm_pkg::EXP_W:0] bx;
		logic signed [gdm_pkg::EXP_W:0] s;
		logic signed [gdm_pkg::EXP_W:0] hi_x;
		logic signed [gdm_pkg::EXP_W:0] lo_x;
		gdm_pkg::exp_t r;
		ax = {a[gdm_pkg::EXP_W-1], a};
		bx = {b[gdm_pkg::EXP_W-1], b};
		hi_x = {gdm_pkg::FIN_MAX[gdm_pkg::EXP_W-1], gdm_pkg::FIN_MAX};
		lo_x = {gdm_pkg::FIN_MIN[gdm_pkg::EXP_W-1], gdm_pkg::FIN_MIN};
		s = sub ? (ax - bx) : (ax + bx);
		if (s > hi_x) begin
			r.val = gdm_pkg::FIN_MAX;
			r.sat = 1'b1;
		end else if (s < lo_x) begin
			r.val = gdm_pkg::FIN_MIN;
			r.sat = 1'b1;
		end else begin
			r.val = s[gdm_pkg::EXP_W-1:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

	// sum where hi absorbs first, then lo
	function automatic gdm_pkg::exp_t abs_sum(
		input logic signed [gdm_pkg::EXP_W-1:0] a,
		input logic signed [gdm_pkg::EXP_W-1:0] b,
		input logic signed [gdm_pkg::EXP_W-1:0] hi,
		input logic signed [gdm_pkg::EXP_W-1:0] lo
	);
		gdm_pkg::exp_t r;
		r.sat = 1'b0;
		if (a == hi || b == hi) begin
			r.val = hi;
		end else if (a == lo || b == lo) begin
			r.val = lo;
		end else begin
			r = sat_op(a, b, 1'b0);
		end
		return r;
	endfunction

	// residuation difference, lo is the bottom code
	function automatic gdm_pkg::exp_t res_diff(
		input logic signed [gdm_pkg::EXP_W-1:0] a,
		input logic signed [gdm_pkg::EXP_W-1:0] b,
		input logic signed [gdm_pkg::EXP_W-1:0] lo,
		input logic signed [gdm_pkg::EXP_W-1:0] hi
	);
		gdm_pkg::exp_t r;
		r.sat = 1'b0;
		if (a == lo) begin
			r.val = lo;
		end else if (a == hi) begin
			r.val = (b == hi) ? lo : hi;
		end else if (b == hi) begin
			r.val = lo;
		end else if (b == lo) begin
			r.val = hi;
		end else begin
			r = sat_op(a, b, 1'b1);
		end
		return r;
	endfunction

	logic signed [gdm_pkg::EXP_W-1:0] ag;
	logic signed [gdm_pkg::EXP_W-1:0] ad;
	logic signed [gdm_pkg::EXP_W-1:0] bg;
	logic signed [gdm_pkg::EXP_W-1:0] bd;
	gdm_pkg::exp_t                    g_r;
	gdm_pkg::exp_t                    d_r;
	logic                             undef;

	assign ag = norm(a_gamma);
	assign ad = norm(a_delta);
	assign bg = norm(b_gamma);
	assign bd = norm(b_delta);

	always_comb begin
		g_r   = '{val: gdm_pkg::POS_INF, sat: 1'b0};
		d_r   = '{val: gdm_pkg::NEG_INF, sat: 1'b0};
		undef = 1'b0;
		unique case (gdm_pkg::cmd_t'(command))
			gdm_pkg::CMD_PROD: begin
				g_r = abs_sum(ag, bg, gdm_pkg::POS_INF, gdm_pkg::NEG_INF);
				d_r = abs_sum(ad, bd, gdm_pkg::NEG_INF, gdm_pkg::POS_INF);
			end
			gdm_pkg::CMD_RES: begin
				g_r = res_diff(ag, bg, gdm_pkg::NEG_INF, gdm_pkg::POS_INF);
				d_r = res_diff(ad, bd, gdm_pkg::POS_INF, gdm_pkg::NEG_INF);
			end
			gdm_pkg::CMD_DRES: begin
				g_r = res_diff(ag, bg, gdm_pkg::POS_INF, gdm_pkg::NEG_INF);
				d_r = res_diff(ad, bd, gdm_pkg::NEG_INF, gdm_pkg::POS_INF);
			end
			gdm_pkg::CMD_HPROD: begin
				d_r.val = (ad < bd) ? ad : bd;
				g_r     = abs_sum(ag, bg, gdm_pkg::POS_INF, gdm_pkg::NEG_INF);
			end
			gdm_pkg::CMD_HRES: begin
				d_r.val = (ad >= bd) ? gdm_pkg::POS_INF : ad;
				if (ag == gdm_pkg::NEG_INF || bg == gdm_pkg::POS_INF) begin
					g_r.val = gdm_pkg::NEG_INF;
				end else if (ag == gdm_pkg::POS_INF || bg == gdm_pkg::NEG_INF) begin
					g_r.val = gdm_pkg::POS_INF;
				end else begin
					g_r = sat_op(ag, bg, 1'b1);
				end
			end
			gdm_pkg::CMD_HDRES: begin
				if (ad > bd || ((bg == gdm_pkg::POS_INF || bg == gdm_pkg::NEG_INF) &&
						ag != gdm_pkg::POS_INF)) begin
					undef   = 1'b1;
					g_r.val = gdm_pkg::NEG_INF;
					d_r.val = gdm_pkg::POS_INF;
				end else begin
					d_r.val = ad;
					if (ag == gdm_pkg::POS_INF) begin
						g_r.val = gdm_pkg::POS_INF;
					end else begin
						g_r = sat_op(ag, bg, 1'b1);
					end
				end
			end
			default: begin
				// unused codes give the zero monomial
				g_r   = '{val: gdm_pkg::POS_INF, sat: 1'b0};
				d_r   = '{val: gdm_pkg::NEG_INF, sat: 1'b0};
				undef = 1'b0;
			end
		endcase
	end

	assign res.gamma     = g_r.val;
	assign res.delta     = d_r.val;
	assign res.undefined = undef;
	assign res.saturated = g_r.sat | d_r.sat;

endmodule

// ----- src/gamma_delta_monomial_alu.sv -----
// channel   direction  handshake                    payload
// item      in         item_valid / item_stall      command, a_gamma, a_delta, b_gamma, b_delta
// result    out        result_valid / result_stall  result_gamma, result_delta, undefined,
//                                                   saturated
//
// two register stages: operands are captured in s1, the result of the alu lands in s2
// an accepted item beat passes s1 then s2 to its result beat, one beat per cycle while result_stall is low
// arst_n clears only the stage valid bits, payload registers are not reset
// result_stall holds s2; s1 still loads while s2 is full but s1 is empty or draining
// item_stall is raised only when both stages hold beats and the result side is stalled
module gamma_delta_monomial_alu (
	input  logic                             clk,
	input  logic                             arst_n,
	// item channel
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic [2:0]                       command,
	input  logic signed [gdm_pkg::EXP_W-1:0] a_gamma,
	input  logic signed [gdm_pkg::EXP_W-1:0] a_delta,
	input  logic signed [gdm_pkg::EXP_W-1:0] b_gamma,
	input  logic signed [gdm_pkg::EXP_W-1:0] b_delta,
	// result channel
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic signed [gdm_pkg::EXP_W-1:0] result_gamma,
	output logic signed [gdm_pkg::EXP_W-1:0] result_delta,
	output logic                             undefined,
	output logic                             saturated
);

	// operand stage
	logic                             valid_s1;
	logic [2:0]                       command_s1;
	logic signed [gdm_pkg::EXP_W-1:0] a_gamma_s1;
	logic signed [gdm_pkg::EXP_W-1:0] a_delta_s1;
	logic signed [gdm_pkg::EXP_W-1:0] b_gamma_s1;
	logic signed [gdm_pkg::EXP_W-1:0] b_delta_s1;

	// result stage
	logic                             valid_s2;
	gdm_pkg::res_t                    res_s2;

	gdm_pkg::res_t                    alu_res;
	logic                             load_s2;
	logic                             load_s1;

	// s2 may take a new beat when empty or when its beat leaves this cycle
	assign load_s2    = !valid_s2 || !result_stall;
	// s1 may take a new beat when empty or when its beat moves into s2
	assign load_s1    = !valid_s1 || load_s2;
	assign item_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= item_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && item_valid) begin
			command_s1 <= command;
			a_gamma_s1 <= a_gamma;
			a_delta_s1 <= a_delta;
			b_gamma_s1 <= b_gamma;
			b_delta_s1 <= b_delta;
		end
		if (load_s2 && valid_s1) begin
			res_s2 <= alu_res;
		end
	end

	// all six operations are adds, compares and selects in one pass
	gdm_alu u_alu (
		.command (command_s1),
		.a_gamma (a_gamma_s1),
		.a_delta (a_delta_s1),
		.b_gamma (b_gamma_s1),
		.b_delta (b_delta_s1),
		.res     (alu_res)
	);

	assign result_valid = valid_s2;
	assign result_gamma = res_s2.gamma;
	assign result_delta = res_s2.delta;
	assign undefined    = res_s2.undefined;
	assign saturated    = res_s2.saturated;

endmodule
